### src/phase_current_offset_average_defines.svh
// Assertion macros shared by the phase current offset and average block.
`ifndef PHASE_CURRENT_OFFSET_AVERAGE_DEFINES_SVH
`define PHASE_CURRENT_OFFSET_AVERAGE_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define PCOA_CHECK(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("pcoa check failed");

// Condition in one cycle that implies a consequence in the next.
`define PCOA_CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pcoa next-cycle check failed");

`endif

### src/pcoa_pkg.sv
// Package: widths, constants, types and saturation helper for the current filter.
package pcoa_pkg;

    localparam int SAMPLE_BITS   = 12;
    localparam int FRAC_BITS     = 4;
    localparam int WINDOW_LEN    = 16;
    localparam int DISCARD_COUNT = 500;
    localparam int AVERAGE_COUNT = 1000;

    localparam int GAIN_W    = 24;
    localparam int GAIN_FRAC = 16;
    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(65536);
    localparam int OUT_W     = 24;

    // difference with fraction bits, offset, corrected sample
    localparam int D_W    = SAMPLE_BITS + 1 + FRAC_BITS;
    localparam int OFF_W  = D_W + 1;
    localparam int C_W    = OFF_W + 1;
    localparam int WSUM_W = C_W + $clog2(WINDOW_LEN + 1);
    localparam int CAL_W  = D_W + $clog2(AVERAGE_COUNT) + 1;

    localparam int IDX_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int FILL_W = $clog2(WINDOW_LEN + 1);
    localparam int CNT_MAX = (DISCARD_COUNT > AVERAGE_COUNT) ? DISCARD_COUNT : AVERAGE_COUNT;
    localparam int CNT_W  = $clog2(CNT_MAX + 1);

    // serial divide / multiply unit
    localparam int NUM_W   = (CAL_W > WSUM_W) ? CAL_W : WSUM_W;
    localparam int DIV_W   = NUM_W + 1;
    localparam int DEN_MAX = (AVERAGE_COUNT > WINDOW_LEN) ? AVERAGE_COUNT : WINDOW_LEN;
    localparam int DEN_W   = $clog2(DEN_MAX + 1);
    localparam int A_W     = C_W;
    localparam int PROD_W  = A_W + GAIN_W;
    localparam int SAT_W   = PROD_W - GAIN_FRAC + 1;
    localparam int STEP_MAX = (DIV_W > GAIN_W) ? DIV_W : GAIN_W;
    localparam int STEP_W  = $clog2(STEP_MAX);

    localparam int IN_W       = ((4 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((3 * OUT_W + 7) / 8) * 8;

    localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'((1 << (OUT_W - 1)) - 1);
    localparam logic signed [SAT_W-1:0] SAT_LO = ~SAT_HI;

    typedef struct packed {
        logic start;
        logic mul;
    } t_unit_req;

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SAT_W-1:0] v);
        logic signed [OUT_W-1:0] r;
        if (v > SAT_HI) begin
            r = {1'b0, {(OUT_W-1){1'b1}}};
        end else if (v < SAT_LO) begin
            r = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

### src/pcoa_divmul.sv
// Bit-serial rounded divider, optionally followed by a shift-add gain multiplier with rounding and saturation.
module pcoa_divmul (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pcoa_pkg::t_unit_req                 i_req,
    input  logic signed [pcoa_pkg::NUM_W-1:0]   i_num,
    input  logic [pcoa_pkg::DEN_W-1:0]          i_den,
    input  logic [pcoa_pkg::GAIN_W-1:0]         i_gain,
    output logic                                o_done,
    output logic signed [pcoa_pkg::A_W-1:0]     o_quot,
    output logic signed [pcoa_pkg::OUT_W-1:0]   o_cur
);

    localparam int NUM_W  = pcoa_pkg::NUM_W;
    localparam int DIV_W  = pcoa_pkg::DIV_W;
    localparam int DEN_W  = pcoa_pkg::DEN_W;
    localparam int A_W    = pcoa_pkg::A_W;
    localparam int GAIN_W = pcoa_pkg::GAIN_W;
    localparam int PROD_W = pcoa_pkg::PROD_W;
    localparam int SAT_W  = pcoa_pkg::SAT_W;
    localparam int STEP_W = pcoa_pkg::STEP_W;
    localparam int GFRAC  = pcoa_pkg::GAIN_FRAC;

    typedef enum logic [2:0] {
        U_IDLE,
        U_DIV,
        U_LOAD,
        U_MUL,
        U_FIN
    } t_ustate;

    t_ustate                  r_state;
    logic [STEP_W-1:0]        r_step;
    logic                     r_neg;
    logic                     r_mul;
    logic [DIV_W-1:0]         r_dvd;
    logic [DEN_W-1:0]         r_rem;
    logic [DEN_W-1:0]         r_den;
    logic [PROD_W-1:0]        r_prod;
    logic [A_W-1:0]           r_mcand;
    logic                     r_done;
    logic signed [A_W-1:0]    r_quot;
    logic signed [pcoa_pkg::OUT_W-1:0] r_cur;

    logic signed [NUM_W:0]    num_x;
    logic [DIV_W-1:0]         n_dvd_init;
    logic [DEN_W:0]           trial;
    logic                     fits;
    logic [DEN_W:0]           rem_sub;
    logic [A_W:0]             psum;
    logic [PROD_W-1:0]        n_prod;
    logic [PROD_W-1:0]        rounded;
    logic signed [SAT_W-1:0]  cur_mag;
    logic signed [SAT_W-1:0]  cur_val;
    logic signed [A_W:0]      q_mag;
    logic signed [A_W:0]      q_val;

    always_comb begin
        num_x      = (NUM_W+1)'(i_num);
        n_dvd_init = DIV_W'(i_num[NUM_W-1] ? -num_x : num_x) + DIV_W'(i_den >> 1);

        // restoring step: one quotient bit per cycle, shifted into the dividend word
        trial   = {r_rem, r_dvd[DIV_W-1]};
        fits    = trial >= {1'b0, r_den};
        rem_sub = fits ? (trial - {1'b0, r_den}) : trial;

        // LSB-first shift-add over the gain bits held in the low part of r_prod
        psum   = {1'b0, r_prod[PROD_W-1:GAIN_W]} + (r_prod[0] ? {1'b0, r_mcand} : '0);
        n_prod = {psum, r_prod[GAIN_W-1:1]};

        rounded = r_prod + PROD_W'(1 << (GFRAC - 1));
        cur_mag = $signed({1'b0, rounded[PROD_W-1:GFRAC]});
        cur_val = r_neg ? -cur_mag : cur_mag;

        q_mag = $signed({1'b0, r_dvd[A_W-1:0]});
        q_val = r_neg ? -q_mag : q_mag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= r_state == U_FIN;
            unique case (r_state)
                U_IDLE: begin
                    if (i_req.start) begin
                        r_neg   <= i_num[NUM_W-1];
                        r_mul   <= i_req.mul;
                        r_dvd   <= n_dvd_init;
                        r_den   <= i_den;
                        r_rem   <= '0;
                        r_step  <= STEP_W'(DIV_W - 1);
                        r_state <= U_DIV;
                    end
                end
                U_DIV: begin
                    r_rem  <= rem_sub[DEN_W-1:0];
                    r_dvd  <= {r_dvd[DIV_W-2:0], fits};
                    r_step <= r_step - 1'b1;
                    if (r_step == '0) begin
                        r_state <= r_mul ? U_LOAD : U_FIN;
                    end
                end
                U_LOAD: begin
                    r_mcand <= r_dvd[A_W-1:0];
                    r_prod  <= {{A_W{1'b0}}, i_gain};
                    r_step  <= STEP_W'(GAIN_W - 1);
                    r_state <= U_MUL;
                end
                U_MUL: begin
                    r_prod <= n_prod;
                    r_step <= r_step - 1'b1;
                    if (r_step == '0) begin
                        r_state <= U_FIN;
                    end
                end
                U_FIN: begin
                    r_quot  <= q_val[A_W-1:0];
                    r_cur   <= pcoa_pkg::sat_out(cur_val);
                    r_state <= U_IDLE;
                end
                default: r_state <= U_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_cur  = r_cur;

endmodule

### src/phase_current_offset_average.sv
// Top level: offset calibration, moving-average window and milliamp scaling of U/V currents.
//
// Usage:
//  - s_axis carries one conversion word per handshake (tvalid & tready): U/V signal and
//    reference counts. m_axis carries one result word: filtered U, V and W = -(U+V) in mA.
//  - i_cfg_we / i_cfg_wdata write the current gain (unsigned Q16, mA per 1/16 count).
//  - After reset the first DISCARD_COUNT words are dropped and the next AVERAGE_COUNT words
//    build the per-phase offsets; none of them gives a result. Every later word gives one.
//  - One word at a time: the next word is accepted only after the current one is done. The
//    word that closes calibration runs one serial division per phase.
//  - For a running word, both lanes run a 29-step restoring divider (window sum by fill
//    count), then a 24-step shift-add gain multiply.
//  - Results sit in an output register; the next word is accepted while it waits. If the
//    receiver still stalls when the following result is done, the block holds it and takes
//    no input until the output register frees.
//  - Reset is synchronous, active low: it restarts calibration and empties the window.
//    The ring needs no clearing pass: entries read from it are only used once the window is full.
`include "phase_current_offset_average_defines.svh"

module phase_current_offset_average (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [pcoa_pkg::GAIN_W-1:0]          i_cfg_wdata,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // u_signal, v_signal, u_reference, v_reference
    input  logic [pcoa_pkg::IN_W-1:0]            s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // current_u, current_v, current_w
    output logic [pcoa_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);

    localparam int SB     = pcoa_pkg::SAMPLE_BITS;
    localparam int D_W    = pcoa_pkg::D_W;
    localparam int OFF_W  = pcoa_pkg::OFF_W;
    localparam int C_W    = pcoa_pkg::C_W;
    localparam int WSUM_W = pcoa_pkg::WSUM_W;
    localparam int CAL_W  = pcoa_pkg::CAL_W;
    localparam int IDX_W  = pcoa_pkg::IDX_W;
    localparam int FILL_W = pcoa_pkg::FILL_W;
    localparam int CNT_W  = pcoa_pkg::CNT_W;
    localparam int NUM_W  = pcoa_pkg::NUM_W;
    localparam int DEN_W  = pcoa_pkg::DEN_W;
    localparam int A_W    = pcoa_pkg::A_W;
    localparam int OUT_W  = pcoa_pkg::OUT_W;
    localparam int SAT_W  = pcoa_pkg::SAT_W;
    localparam int WLEN   = pcoa_pkg::WINDOW_LEN;

    typedef enum logic [1:0] {
        M_DISCARD,
        M_AVERAGE,
        M_RUN
    } t_mode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_RING,
        S_CAL_DIV,
        S_CAL_WAIT,
        S_RUN_DIV,
        S_RUN_WAIT,
        S_PUT
    } t_state;

    t_state                     r_state;
    t_mode                      r_mode;
    logic [CNT_W-1:0]           r_cnt;
    logic [pcoa_pkg::GAIN_W-1:0] r_gain;
    logic signed [D_W-1:0]      r_du, r_dv;
    logic signed [CAL_W-1:0]    r_cal_u, r_cal_v;
    logic signed [OFF_W-1:0]    r_off_u, r_off_v;
    logic signed [C_W-1:0]      r_cu, r_cv;
    logic signed [C_W-1:0]      r_old_u, r_old_v;
    logic signed [WSUM_W-1:0]   r_wsum_u, r_wsum_v;
    logic [IDX_W-1:0]           r_idx;
    logic [FILL_W-1:0]          r_fill;
    logic signed [OUT_W-1:0]    r_iu, r_iv;
    logic                       r_m_valid;
    logic [pcoa_pkg::OUT_DATA_W-1:0] r_m_data;

    logic signed [C_W-1:0]      ring_u [WLEN];
    logic signed [C_W-1:0]      ring_v [WLEN];

    logic signed [SB:0]         diff_u, diff_v;
    logic signed [D_W-1:0]      n_du, n_dv;
    logic signed [C_W-1:0]      n_cu, n_cv;
    logic                       win_full;
    logic [IDX_W-1:0]           ring_waddr;
    logic signed [OUT_W:0]      uv_sum;
    logic signed [SAT_W-1:0]    w_val;
    logic signed [OUT_W-1:0]    n_iw;

    pcoa_pkg::t_unit_req        unit_req;
    logic signed [NUM_W-1:0]    num_u, num_v;
    logic [DEN_W-1:0]           unit_den;
    logic                       w_done_u, w_done_v;
    logic signed [A_W-1:0]      quot_u, quot_v;
    logic signed [OUT_W-1:0]    cur_u, cur_v;

    always_comb begin
        diff_u = $signed({1'b0, s_axis_tdata[SB-1:0]}) - $signed({1'b0, s_axis_tdata[3*SB-1:2*SB]});
        diff_v = $signed({1'b0, s_axis_tdata[2*SB-1:SB]}) - $signed({1'b0, s_axis_tdata[4*SB-1:3*SB]});
        n_du   = $signed({diff_u, {pcoa_pkg::FRAC_BITS{1'b0}}});
        n_dv   = $signed({diff_v, {pcoa_pkg::FRAC_BITS{1'b0}}});

        n_cu = C_W'(r_du) - C_W'(r_off_u);
        n_cv = C_W'(r_dv) - C_W'(r_off_v);

        win_full   = r_fill == FILL_W'(WLEN);
        ring_waddr = win_full ? r_idx : r_fill[IDX_W-1:0];

        uv_sum = (OUT_W+1)'(r_iu) + (OUT_W+1)'(r_iv);
        w_val  = -SAT_W'(uv_sum);
        n_iw   = pcoa_pkg::sat_out(w_val);

        unit_req.start = (r_state == S_CAL_DIV) || (r_state == S_RUN_DIV);
        unit_req.mul   = r_state == S_RUN_DIV;
        num_u    = (r_state == S_RUN_DIV) ? NUM_W'(r_wsum_u) : NUM_W'(r_cal_u);
        num_v    = (r_state == S_RUN_DIV) ? NUM_W'(r_wsum_v) : NUM_W'(r_cal_v);
        unit_den = (r_state == S_RUN_DIV) ? DEN_W'(r_fill) : DEN_W'(pcoa_pkg::AVERAGE_COUNT);
    end

    pcoa_divmul u_lane_u (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (unit_req),
        .i_num   (num_u),
        .i_den   (unit_den),
        .i_gain  (r_gain),
        .o_done  (w_done_u),
        .o_quot  (quot_u),
        .o_cur   (cur_u)
    );

    pcoa_divmul u_lane_v (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (unit_req),
        .i_num   (num_v),
        .i_den   (unit_den),
        .i_gain  (r_gain),
        .o_done  (w_done_v),
        .o_quot  (quot_v),
        .o_cur   (cur_v)
    );

    // ring storage: one read port for the oldest entry, one write port
    always_ff @(posedge i_clk) begin
        if (r_state == S_EVAL) begin
            r_old_u <= ring_u[r_idx];
            r_old_v <= ring_v[r_idx];
        end
        if (r_state == S_RING) begin
            ring_u[ring_waddr] <= r_cu;
            ring_v[ring_waddr] <= r_cv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= pcoa_pkg::GAIN_RESET;
        end else if (i_cfg_we) begin
            r_gain <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_mode    <= M_DISCARD;
            r_cnt     <= '0;
            r_cal_u   <= '0;
            r_cal_v   <= '0;
            r_off_u   <= '0;
            r_off_v   <= '0;
            r_wsum_u  <= '0;
            r_wsum_v  <= '0;
            r_idx     <= '0;
            r_fill    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            // S_PUT refills the output register itself
            if (r_m_valid && m_axis_tready && (r_state != S_PUT)) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_du    <= n_du;
                        r_dv    <= n_dv;
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    unique case (r_mode)
                        M_DISCARD: begin
                            if (r_cnt < CNT_W'(pcoa_pkg::DISCARD_COUNT)) begin
                                if (r_cnt == CNT_W'(pcoa_pkg::DISCARD_COUNT - 1)) begin
                                    r_mode <= M_AVERAGE;
                                    r_cnt  <= '0;
                                end else begin
                                    r_cnt <= r_cnt + 1'b1;
                                end
                                r_state <= S_IDLE;
                            end else begin
                                // nothing to drop: this word goes to the average
                                r_mode <= M_AVERAGE;
                                r_cnt  <= '0;
                            end
                        end
                        M_AVERAGE: begin
                            r_cal_u <= r_cal_u + CAL_W'(r_du);
                            r_cal_v <= r_cal_v + CAL_W'(r_dv);
                            if (r_cnt == CNT_W'(pcoa_pkg::AVERAGE_COUNT - 1)) begin
                                r_cnt   <= '0;
                                r_state <= S_CAL_DIV;
                            end else begin
                                r_cnt   <= r_cnt + 1'b1;
                                r_state <= S_IDLE;
                            end
                        end
                        M_RUN: begin
                            r_cu    <= n_cu;
                            r_cv    <= n_cv;
                            r_state <= S_RING;
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end
                S_RING: begin
                    if (win_full) begin
                        r_wsum_u <= r_wsum_u + WSUM_W'(r_cu) - WSUM_W'(r_old_u);
                        r_wsum_v <= r_wsum_v + WSUM_W'(r_cv) - WSUM_W'(r_old_v);
                        r_idx    <= (r_idx == IDX_W'(WLEN - 1)) ? '0 : r_idx + 1'b1;
                    end else begin
                        r_wsum_u <= r_wsum_u + WSUM_W'(r_cu);
                        r_wsum_v <= r_wsum_v + WSUM_W'(r_cv);
                        r_fill   <= r_fill + 1'b1;
                    end
                    r_state <= S_RUN_DIV;
                end
                S_CAL_DIV: r_state <= S_CAL_WAIT;
                S_CAL_WAIT: begin
                    if (w_done_u) begin
                        r_off_u  <= quot_u[OFF_W-1:0];
                        r_off_v  <= quot_v[OFF_W-1:0];
                        r_wsum_u <= '0;
                        r_wsum_v <= '0;
                        r_idx    <= '0;
                        r_fill   <= '0;
                        r_mode   <= M_RUN;
                        r_state  <= S_IDLE;
                    end
                end
                S_RUN_DIV: r_state <= S_RUN_WAIT;
                S_RUN_WAIT: begin
                    if (w_done_u) begin
                        r_iu    <= cur_u;
                        r_iv    <= cur_v;
                        r_state <= S_PUT;
                    end
                end
                S_PUT: begin
                    if (!r_m_valid || m_axis_tready) begin
                        r_m_data  <= pcoa_pkg::OUT_DATA_W'({n_iw, r_iv, r_iu});
                        r_m_valid <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = r_state == S_IDLE;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    `PCOA_CHECK(a_fill_range, r_fill <= FILL_W'(WLEN))
    `PCOA_CHECK(a_lanes_in_step, w_done_u == w_done_v)
    `PCOA_CHECK_NEXT(a_run_sticky, r_mode == M_RUN, r_mode == M_RUN)
    `PCOA_CHECK(a_result_after_put, $rose(m_axis_tvalid) |-> $past(r_state == S_PUT))

endmodule

### tb/tb_phase_current_offset_average.sv
// Testbench: offset calibration, moving-average window and milliamp scaling of U/V currents.
`timescale 1ns / 1ps

module tb_phase_current_offset_average;

    localparam int SAMPLE_BITS   = pcoa_pkg::SAMPLE_BITS;
    localparam int FRAC_BITS     = pcoa_pkg::FRAC_BITS;
    localparam int WINDOW_LEN    = pcoa_pkg::WINDOW_LEN;
    localparam int DISCARD_COUNT = pcoa_pkg::DISCARD_COUNT;
    localparam int AVERAGE_COUNT = pcoa_pkg::AVERAGE_COUNT;
    localparam int GAIN_W        = pcoa_pkg::GAIN_W;
    localparam int OUT_W         = pcoa_pkg::OUT_W;
    localparam int CNT_W         = pcoa_pkg::CNT_W;
    localparam int CAL_W         = pcoa_pkg::CAL_W;
    localparam int OFF_W         = pcoa_pkg::OFF_W;
    localparam int C_W           = pcoa_pkg::C_W;
    localparam int WSUM_W        = pcoa_pkg::WSUM_W;
    localparam int IDX_W         = pcoa_pkg::IDX_W;
    localparam int FILL_W        = pcoa_pkg::FILL_W;
    localparam int IN_W          = pcoa_pkg::IN_W;
    localparam int OUT_DATA_W    = pcoa_pkg::OUT_DATA_W;
    localparam logic [GAIN_W-1:0] GAIN_RESET = pcoa_pkg::GAIN_RESET;
    localparam longint SAT_HI    = longint'(pcoa_pkg::SAT_HI);
    localparam longint SAT_LO    = longint'(pcoa_pkg::SAT_LO);

    localparam int SAMPLE_MAX    = (1 << SAMPLE_BITS) - 1;
    localparam int SETTLE_CYCLES = 100;
    localparam logic [SAMPLE_BITS-1:0] COUNT_FULL = SAMPLE_BITS'(SAMPLE_MAX);
    localparam logic [SAMPLE_BITS-1:0] COUNT_ZERO = '0;
    localparam logic [SAMPLE_BITS-1:0] COUNT_ALT_A = SAMPLE_BITS'('hAAA);
    localparam logic [SAMPLE_BITS-1:0] COUNT_ALT_5 = SAMPLE_BITS'('h555);

    // Predicts the filtered currents from each accepted conversion word.
    class current_scoreboard;
        typedef enum logic [1:0] {CAL_DROP, CAL_SUM, RUNNING} t_stage;

        t_stage                    stage;
        logic [CNT_W-1:0]          sample_count;
        logic signed [CAL_W-1:0]   cal_acc_u, cal_acc_v;
        logic signed [OFF_W-1:0]   offset_u, offset_v;
        logic signed [C_W-1:0]     ring_u [WINDOW_LEN];
        logic signed [C_W-1:0]     ring_v [WINDOW_LEN];
        logic signed [WSUM_W-1:0]  win_sum_u, win_sum_v;
        logic [IDX_W-1:0]          ring_ptr;
        logic [FILL_W-1:0]         fill;
        logic [GAIN_W-1:0]         gain;
        logic [OUT_DATA_W-1:0]     expected_q [$];
        int                        errors;
        int                        checked;

        function new();
            stage        = CAL_DROP;
            sample_count = '0;
            cal_acc_u    = '0;
            cal_acc_v    = '0;
            offset_u     = '0;
            offset_v     = '0;
            gain         = GAIN_RESET;
            errors       = 0;
            checked      = 0;
            clear_window();
        endfunction

        function void clear_window();
            foreach (ring_u[i]) begin
                ring_u[i] = '0;
                ring_v[i] = '0;
            end
            win_sum_u = '0;
            win_sum_v = '0;
            ring_ptr  = '0;
            fill      = '0;
        endfunction

        // nearest, ties away from zero
        function longint div_near(longint num, longint den);
            longint mag;
            longint q;
            mag = (num < 0) ? -num : num;
            q = (mag + den / 2) / den;
            return (num < 0) ? -q : q;
        endfunction

        function longint limit_out(longint v);
            if (v > SAT_HI) return SAT_HI;
            if (v < SAT_LO) return SAT_LO;
            return v;
        endfunction

        function longint to_ma(longint avg);
            return limit_out(div_near(avg * longint'(gain), longint'(65536)));
        endfunction

        function void set_gain(logic [GAIN_W-1:0] g);
            gain = g;
        endfunction

        function void note_word(logic [IN_W-1:0] w);
            longint           du, dv, cu, cv, iu, iv, iw;
            logic [IDX_W-1:0] k;
            du = (longint'(w[SAMPLE_BITS-1:0]) - longint'(w[3*SAMPLE_BITS-1:2*SAMPLE_BITS]))
                 * (1 << FRAC_BITS);
            dv = (longint'(w[2*SAMPLE_BITS-1:SAMPLE_BITS]) - longint'(w[4*SAMPLE_BITS-1:3*SAMPLE_BITS]))
                 * (1 << FRAC_BITS);

            if (stage == CAL_DROP) begin
                if (sample_count < DISCARD_COUNT) begin
                    sample_count++;
                    if (sample_count >= DISCARD_COUNT) begin
                        stage        = CAL_SUM;
                        sample_count = '0;
                    end
                    return;
                end
                stage        = CAL_SUM;
                sample_count = '0;
            end

            if (stage == CAL_SUM) begin
                cal_acc_u = CAL_W'(longint'(cal_acc_u) + du);
                cal_acc_v = CAL_W'(longint'(cal_acc_v) + dv);
                sample_count++;
                if (sample_count >= AVERAGE_COUNT) begin
                    offset_u = OFF_W'(div_near(longint'(cal_acc_u), longint'(AVERAGE_COUNT)));
                    offset_v = OFF_W'(div_near(longint'(cal_acc_v), longint'(AVERAGE_COUNT)));
                    clear_window();
                    stage        = RUNNING;
                    sample_count = '0;
                end
                return;
            end

            cu = du - longint'(offset_u);
            cv = dv - longint'(offset_v);
            if (fill < WINDOW_LEN) begin
                ring_u[fill[IDX_W-1:0]] = C_W'(cu);
                ring_v[fill[IDX_W-1:0]] = C_W'(cv);
                fill++;
            end else begin
                k = ring_ptr;
                win_sum_u = WSUM_W'(longint'(win_sum_u) - longint'(ring_u[k]));
                win_sum_v = WSUM_W'(longint'(win_sum_v) - longint'(ring_v[k]));
                ring_u[k] = C_W'(cu);
                ring_v[k] = C_W'(cv);
                ring_ptr  = IDX_W'((k + 1) % WINDOW_LEN);
            end
            win_sum_u = WSUM_W'(longint'(win_sum_u) + cu);
            win_sum_v = WSUM_W'(longint'(win_sum_v) + cv);

            // while the ring fills the average is over the fill count
            iu = to_ma(div_near(longint'(win_sum_u), longint'(fill)));
            iv = to_ma(div_near(longint'(win_sum_v), longint'(fill)));
            iw = limit_out(-(iu + iv));
            expected_q.push_back(OUT_DATA_W'({OUT_W'(iw), OUT_W'(iv), OUT_W'(iu)}));
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_word(logic [OUT_DATA_W-1:0] got);
            logic [OUT_DATA_W-1:0] want;
            checked++;
            if (expected_q.size() == 0) begin
                report($sformatf("result %0d arrived with nothing expected", checked));
                return;
            end
            want = expected_q.pop_front();
            for (int i = 0; i < 3; i++) begin
                if (got[i*OUT_W +: OUT_W] !== want[i*OUT_W +: OUT_W]) begin
                    report($sformatf("result %0d %s: got %0d, want %0d", checked,
                        (i == 0) ? "current_u" : (i == 1) ? "current_v" : "current_w",
                        $signed(got[i*OUT_W +: OUT_W]), $signed(want[i*OUT_W +: OUT_W])));
                end
            end
        endtask
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [GAIN_W-1:0]      i_cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_W-1:0]        s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;

    current_scoreboard sb = new();
    int tx_count = 0;
    int bias_u = 0;
    int bias_v = 0;

    always #1 i_clk = ~i_clk;

    phase_current_offset_average u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    function automatic int noise(int s);
        return int'($urandom_range(0, 2 * s)) - s;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] clamp_count(int x);
        if (x < 0) return '0;
        if (x > SAMPLE_MAX) return SAMPLE_BITS'(SAMPLE_MAX);
        return SAMPLE_BITS'(x);
    endfunction

    // word fields from bit 0: u_signal, v_signal, u_reference, v_reference
    function automatic logic [IN_W-1:0] pack_conv(
        input logic [SAMPLE_BITS-1:0] us, vs, ur, vr);
        return IN_W'({vr, ur, vs, us});
    endfunction

    // mostly a plausible conversion: signal = reference + bias + current term
    function automatic logic [IN_W-1:0] make_word(int spread);
        int         kind;
        int         ru, rv;
        logic [63:0] raw;
        kind = $urandom_range(0, 19);
        raw  = {$urandom(), $urandom()};
        if (kind < 2) return raw[IN_W-1:0];
        if (kind < 4) begin
            return pack_conv({SAMPLE_BITS{raw[0]}}, {SAMPLE_BITS{raw[1]}},
                             {SAMPLE_BITS{raw[2]}}, {SAMPLE_BITS{raw[3]}});
        end
        ru = $urandom_range(0, SAMPLE_MAX);
        rv = $urandom_range(0, SAMPLE_MAX);
        return pack_conv(clamp_count(ru + bias_u + noise(spread)),
                         clamp_count(rv + bias_v + noise(spread)),
                         SAMPLE_BITS'(ru), SAMPLE_BITS'(rv));
    endfunction

    task automatic send_word(input logic [IN_W-1:0] w);
        int gap;
        gap = $urandom_range(0, 3);
        if ((tx_count % 150) < 30) gap = 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_word(w);
        tx_count++;
    endtask

    task automatic write_gain(input logic [GAIN_W-1:0] g);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= g;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_gain(g);
    endtask

    // stop offering, let every expected word arrive, then let the block settle
    task automatic finish_phase();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [GAIN_W-1:0] g, input int n, input int spread);
        write_gain(g);
        repeat (n) send_word(make_word(spread));
        finish_phase();
    endtask

    initial begin : result_sink
        int gap;
        int rx_count;
        bit long_hold_done;
        rx_count = 0;
        long_hold_done = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = $urandom_range(0, 3);
            if ((rx_count % 60) < 12) gap = 0;
            // long stall so the output register fills and input backs up
            if (rx_count == 40 && !long_hold_done) begin
                gap = 400;
                long_hold_done = 1'b1;
            end
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            sb.check_word(m_axis_tdata);
            rx_count++;
        end
    end

    initial begin : stimulus
        logic [IN_W-1:0]   corner_words [8];
        logic [GAIN_W-1:0] phase_gain   [6];
        int                phase_spread [6];

        corner_words[0] = pack_conv(COUNT_FULL, COUNT_FULL, COUNT_ZERO, COUNT_ZERO);
        corner_words[1] = pack_conv(COUNT_ZERO, COUNT_ZERO, COUNT_FULL, COUNT_FULL);
        corner_words[2] = pack_conv(COUNT_FULL, COUNT_ZERO, COUNT_ZERO, COUNT_FULL);
        corner_words[3] = pack_conv(COUNT_ZERO, COUNT_FULL, COUNT_FULL, COUNT_ZERO);
        corner_words[4] = pack_conv(COUNT_ZERO, COUNT_ZERO, COUNT_ZERO, COUNT_ZERO);
        corner_words[5] = pack_conv(COUNT_FULL, COUNT_FULL, COUNT_FULL, COUNT_FULL);
        corner_words[6] = pack_conv(COUNT_ALT_A, COUNT_ALT_5, COUNT_ALT_5, COUNT_ALT_A);
        corner_words[7] = pack_conv(COUNT_ALT_5, COUNT_ALT_A, COUNT_ALT_A, COUNT_ALT_5);

        phase_gain[0] = GAIN_RESET;
        phase_gain[1] = '1;
        phase_gain[2] = '0;
        phase_gain[3] = GAIN_W'(1);
        phase_gain[4] = GAIN_W'($urandom());
        phase_gain[5] = GAIN_W'($urandom_range(1000, 300000));
        phase_spread[0] = 2000;
        phase_spread[1] = 800;
        phase_spread[2] = SAMPLE_MAX;
        phase_spread[3] = 50;
        phase_spread[4] = 1500;
        phase_spread[5] = 300;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        bias_u = noise(250);
        bias_v = noise(250);
        write_gain(GAIN_W'($urandom_range(1000, 300000)));

        // calibration: dropped words, then the averaging run; no results
        send_word(corner_words[0]);
        send_word(corner_words[1]);
        repeat (DISCARD_COUNT + AVERAGE_COUNT - 2) send_word(make_word(3));
        finish_phase();

        // first results right after calibration: full-scale gain drives saturation, then zero and minimal gain
        write_gain('1);
        foreach (corner_words[i]) send_word(corner_words[i]);
        finish_phase();
        write_gain('0);
        send_word(corner_words[0]);
        send_word(corner_words[1]);
        finish_phase();
        write_gain(GAIN_W'(1));
        send_word(corner_words[2]);
        send_word(corner_words[3]);
        finish_phase();

        foreach (phase_gain[i]) run_phase(phase_gain[i], 60, phase_spread[i]);

        if (sb.expected_q.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));
        $display("summary: %0d conversion words sent, %0d results checked",
                 tx_count, sb.checked);
        $display("summary: calibration, window fill and wrap, gains zero to full scale, long stall");
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin : watchdog
        #400000;
        $display("tb: failure");
        $finish;
    end

endmodule
